/* rtl/dcc_pkg.sv */
package dcc_pkg;

    // code width of the converter (16 to 20)
    localparam int CODE_BITS = 20;
    // width of the code field in the packet and on the ports
    localparam int DATA_W    = 20;
    localparam int SH        = CODE_BITS - 1;
    localparam int GAIN_FRAC = 29;

    localparam logic [CODE_BITS-1:0] POS_FULL = CODE_BITS'((64'd1 << SH) - 64'd1);
    localparam logic [CODE_BITS-1:0] NEG_FULL = CODE_BITS'(64'd1 << SH);

    localparam logic [7:0] WRITE_CMD = 8'h10;

    // request actions
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_RAW   = 2'd1;
    localparam logic [1:0] ACT_DEC   = 2'd2;
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    // register map
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_UPPER = 3'd0;
    localparam logic [2:0] REG_LOWER = 3'd1;
    localparam logic [2:0] REG_GAIN  = 3'd2;
    localparam logic [2:0] REG_GINV  = 3'd3;
    localparam logic [2:0] REG_OFFS  = 3'd4;
    localparam logic [2:0] REG_FS    = 3'd5;

    // cycles from an accepted request to the edge that takes its result
    localparam int LATENCY = CODE_BITS + 11;

    typedef struct packed {
        logic valid;
        logic ok;
        logic with_packet;
        logic is_set;
    } t_ctl;

    typedef struct packed {
        logic signed [31:0] upper;
        logic signed [31:0] lower;
        logic signed [31:0] gain;
        logic signed [31:0] gain_inv;
        logic signed [31:0] offset;
        logic [30:0]        fs_mag;  // never zero
    } t_cfg;

endpackage

/* rtl/dcc_cfg_regs.sv */
module dcc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output dcc_pkg::t_cfg              o_cfg
);
    import dcc_pkg::*;

    logic signed [31:0] r_upper, r_lower, r_gain, r_ginv, r_offs;
    logic [30:0]        r_fs;
    logic               w_wr;
    logic [2:0]         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= 32'sd655360;
            r_lower <= -32'sd655360;
            r_gain  <= 32'sd536870912;
            r_ginv  <= 32'sd536870912;
            r_offs  <= 32'sd0;
            r_fs    <= 31'd655360;
        end else if (w_wr) begin
            case (w_idx)
                REG_UPPER: r_upper <= pwdata;
                REG_LOWER: r_lower <= pwdata;
                REG_GAIN:  r_gain  <= pwdata;
                REG_GINV:  r_ginv  <= pwdata;
                REG_OFFS:  r_offs  <= pwdata;
                REG_FS:    r_fs    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_UPPER: prdata = r_upper;
            REG_LOWER: prdata = r_lower;
            REG_GAIN:  prdata = r_gain;
            REG_GINV:  prdata = r_ginv;
            REG_OFFS:  prdata = r_offs;
            REG_FS:    prdata = {1'b0, r_fs};
            default:   prdata = 32'd0;
        endcase
    end

    // zero full scale behaves as one
    always_comb begin
        o_cfg.upper    = r_upper;
        o_cfg.lower    = r_lower;
        o_cfg.gain     = r_gain;
        o_cfg.gain_inv = r_ginv;
        o_cfg.offset   = r_offs;
        o_cfg.fs_mag   = (r_fs == 31'd0) ? 31'd1 : r_fs;
    end

endmodule

/* rtl/dcc_encode.sv */
module dcc_encode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [1:0]                    i_action,
    input  logic signed [31:0]            i_voltage,
    input  logic [dcc_pkg::CODE_BITS-1:0] i_code,
    input  dcc_pkg::t_cfg                 i_cfg,
    output dcc_pkg::t_ctl                 o_ctl,
    output logic [dcc_pkg::CODE_BITS-1:0] o_code
);
    import dcc_pkg::*;

    localparam int C_W = 37;
    localparam int N_W = 36 + CODE_BITS;

    // stage 1: input register
    logic                 r1_valid;
    logic [1:0]           r1_action;
    logic signed [31:0]   r1_voltage;
    logic [CODE_BITS-1:0] r1_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else          r1_valid <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        r1_action  <= i_action;
        r1_voltage <= i_voltage;
        r1_code    <= i_code;
    end

    // stage 2: limit check and inverse gain product
    t_ctl                 r2_ctl, w2_ctl;
    logic signed [63:0]   r2_prod;
    logic [CODE_BITS-1:0] r2_code;
    logic                 w_rej;

    always_comb begin
        w_rej = (r1_voltage > i_cfg.upper) || (r1_voltage < i_cfg.lower);
        w2_ctl.valid       = r1_valid;
        w2_ctl.is_set      = (r1_action == ACT_SET);
        w2_ctl.with_packet = (r1_action != ACT_DEC);
        case (r1_action)
            ACT_SET: w2_ctl.ok = !w_rej;
            ACT_RAW: w2_ctl.ok = 1'b1;
            ACT_DEC: w2_ctl.ok = 1'b1;
            default: w2_ctl.ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_ctl <= '0;
        else          r2_ctl <= w2_ctl;
    end
    always_ff @(posedge i_clk) begin
        r2_prod <= r1_voltage * i_cfg.gain_inv;
        r2_code <= r1_code;
    end

    // stage 3: drop gain fraction toward zero, subtract offset
    t_ctl                 r3_ctl;
    logic signed [C_W-1:0] r3_c;
    logic [CODE_BITS-1:0] r3_code;
    logic [63:0]          w_pm, w_pneg;
    logic [34:0]          w_m;
    logic signed [C_W-1:0] w_ms, w_c;

    always_comb begin
        w_pneg = 64'(-r2_prod);
        w_pm   = r2_prod[63] ? w_pneg : r2_prod;
        w_m    = w_pm[63:GAIN_FRAC];
        w_ms   = r2_prod[63] ? -$signed({2'b00, w_m}) : $signed({2'b00, w_m});
        w_c    = w_ms - $signed({{(C_W-32){i_cfg.offset[31]}}, i_cfg.offset});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_ctl <= '0;
        else          r3_ctl <= r2_ctl;
    end
    always_ff @(posedge i_clk) begin
        r3_c    <= w_c;
        r3_code <= r2_code;
    end

    // stage 4: magnitude times full-scale code
    t_ctl                 r4_ctl;
    logic [N_W-1:0]       r4_n;
    logic                 r4_neg;
    logic [CODE_BITS-1:0] r4_code;
    logic signed [C_W-1:0] w_cn;
    logic [35:0]          w_cmag;
    logic [CODE_BITS-1:0] w_k;

    always_comb begin
        w_cn   = -r3_c;
        w_cmag = r3_c[C_W-1] ? w_cn[35:0] : r3_c[35:0];
        w_k    = r3_c[C_W-1] ? NEG_FULL : POS_FULL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_ctl <= '0;
        else          r4_ctl <= r3_ctl;
    end
    always_ff @(posedge i_clk) begin
        r4_n    <= N_W'(w_cmag) * N_W'(w_k);
        r4_neg  <= r3_c[C_W-1];
        r4_code <= r3_code;
    end

    // stage 5 and divider: saturation check, then one quotient bit a stage
    t_ctl                 r_st_ctl  [0:CODE_BITS];
    logic [N_W-1:0]       r_st_rem  [0:CODE_BITS];
    logic [CODE_BITS-1:0] r_st_q    [0:CODE_BITS];
    logic                 r_st_neg  [0:CODE_BITS];
    logic                 r_st_sat  [0:CODE_BITS];
    logic [CODE_BITS-1:0] r_st_code [0:CODE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st_ctl[0] <= '0;
        else          r_st_ctl[0] <= r4_ctl;
    end
    always_ff @(posedge i_clk) begin
        r_st_rem[0]  <= r4_n;
        r_st_q[0]    <= '0;
        r_st_neg[0]  <= r4_neg;
        r_st_sat[0]  <= r4_n >= (N_W'(i_cfg.fs_mag) << CODE_BITS);
        r_st_code[0] <= r4_code;
    end

    for (genvar j = 1; j <= CODE_BITS; j++) begin : g_div
        localparam int BIT = CODE_BITS - j;
        logic [N_W-1:0] w_d;
        logic           w_ge;

        assign w_d  = N_W'(i_cfg.fs_mag) << BIT;
        assign w_ge = r_st_rem[j-1] >= w_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_st_ctl[j] <= '0;
            else          r_st_ctl[j] <= r_st_ctl[j-1];
        end
        always_ff @(posedge i_clk) begin
            r_st_rem[j]  <= w_ge ? (r_st_rem[j-1] - w_d) : r_st_rem[j-1];
            r_st_q[j]    <= r_st_q[j-1] | (w_ge ? (CODE_BITS'(1) << BIT) : '0);
            r_st_neg[j]  <= r_st_neg[j-1];
            r_st_sat[j]  <= r_st_sat[j-1];
            r_st_code[j] <= r_st_code[j-1];
        end
    end

    // code stage: for set requests clamp and form the two's complement code, else pass the input code
    t_ctl                 r_out_ctl;
    logic [CODE_BITS-1:0] r_out_code;
    logic [CODE_BITS-1:0] w_q, w_pos, w_nmag, w_code;

    always_comb begin
        w_q    = r_st_q[CODE_BITS];
        w_pos  = (r_st_sat[CODE_BITS] || (w_q > POS_FULL)) ? POS_FULL : w_q;
        w_nmag = (r_st_sat[CODE_BITS] || (w_q >= NEG_FULL)) ? NEG_FULL : w_q;
        w_code = r_st_neg[CODE_BITS] ? CODE_BITS'(-w_nmag) : w_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_ctl <= '0;
        else          r_out_ctl <= r_st_ctl[CODE_BITS];
    end
    always_ff @(posedge i_clk) begin
        r_out_code <= r_st_ctl[CODE_BITS].is_set ? w_code : r_st_code[CODE_BITS];
    end

    assign o_ctl  = r_out_ctl;
    assign o_code = r_out_code;

endmodule

/* rtl/dcc_report.sv */
module dcc_report (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcc_pkg::t_ctl                 i_ctl,
    input  logic [dcc_pkg::CODE_BITS-1:0] i_code,
    input  dcc_pkg::t_cfg                 i_cfg,
    output logic                          o_done,
    output logic                          o_accepted,
    output logic [23:0]                   o_packet_word,
    output logic [dcc_pkg::DATA_W-1:0]    o_dac_code,
    output logic signed [31:0]            o_reported_voltage
);
    import dcc_pkg::*;

    localparam int X_W = CODE_BITS + 31;

    // stage X: code magnitude times full scale
    t_ctl                 rx_ctl;
    logic [X_W-1:0]       rx_x;
    logic                 rx_neg;
    logic [CODE_BITS-1:0] rx_code;
    logic [CODE_BITS-1:0] w_opd;

    assign w_opd = i_code[CODE_BITS-1] ? CODE_BITS'(-i_code) : i_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rx_ctl <= '0;
        else          rx_ctl <= i_ctl;
    end
    always_ff @(posedge i_clk) begin
        rx_x    <= X_W'(w_opd) * X_W'(i_cfg.fs_mag);
        rx_neg  <= i_code[CODE_BITS-1];
        rx_code <= i_code;
    end

    // stage Y1: first two folds of the divide by 2^SH - 1
    t_ctl                 ry1_ctl;
    logic [32:0]          ry1_a, ry1_a1, ry1_y2;
    logic                 ry1_neg;
    logic [CODE_BITS-1:0] ry1_code;
    logic [32:0]          w_a, w_y1, w_a1, w_y2;

    always_comb begin
        w_a  = 33'(rx_x >> SH);
        w_y1 = w_a + 33'(rx_x[SH-1:0]);
        w_a1 = w_y1 >> SH;
        w_y2 = w_a1 + 33'(w_y1[SH-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ry1_ctl <= '0;
        else          ry1_ctl <= rx_ctl;
    end
    always_ff @(posedge i_clk) begin
        ry1_a    <= w_a;
        ry1_a1   <= w_a1;
        ry1_y2   <= w_y2;
        ry1_neg  <= rx_neg;
        ry1_code <= rx_code;
    end

    // stage Y2: last fold, correction and sign
    t_ctl                 ry2_ctl;
    logic signed [31:0]   ry2_v;
    logic [CODE_BITS-1:0] ry2_code;
    logic [32:0]          w_a2, w_y3, w_q, w_vm;
    logic                 w_corr;

    always_comb begin
        w_a2   = ry1_y2 >> SH;
        w_y3   = w_a2 + 33'(ry1_y2[SH-1:0]);
        w_corr = w_y3 >= 33'(POS_FULL);
        w_q    = ry1_a + ry1_a1 + w_a2 + 33'(w_corr);
        w_vm   = ry1_neg ? ry1_a : w_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ry2_ctl <= '0;
        else          ry2_ctl <= ry1_ctl;
    end
    always_ff @(posedge i_clk) begin
        ry2_v    <= ry1_neg ? -$signed(w_vm[31:0]) : $signed(w_vm[31:0]);
        ry2_code <= ry1_code;
    end

    // stage Z: gain times (voltage + offset)
    t_ctl                 rz_ctl;
    logic signed [64:0]   rz_p;
    logic [CODE_BITS-1:0] rz_code;
    logic signed [32:0]   w_sum;

    assign w_sum = $signed({ry2_v[31], ry2_v}) + $signed({i_cfg.offset[31], i_cfg.offset});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rz_ctl <= '0;
        else          rz_ctl <= ry2_ctl;
    end
    always_ff @(posedge i_clk) begin
        rz_p    <= w_sum * i_cfg.gain;
        rz_code <= ry2_code;
    end

    // output stage: drop fraction toward zero, saturate, pack
    logic [64:0]        w_pneg, w_pm;
    logic [35:0]        w_sh;
    logic [31:0]        w_rv;
    logic [DATA_W-1:0]  w_code;

    always_comb begin
        w_pneg = 65'(-rz_p);
        w_pm   = rz_p[64] ? w_pneg : rz_p;
        w_sh   = w_pm[64:GAIN_FRAC];
        if (rz_p[64])
            w_rv = (w_sh > 36'h080000000) ? 32'h80000000 : 32'(-w_sh[31:0]);
        else
            w_rv = (w_sh > 36'h07FFFFFFF) ? 32'h7FFFFFFF : w_sh[31:0];
        w_code = DATA_W'(rz_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= rz_ctl.valid;
    end
    always_ff @(posedge i_clk) begin
        o_accepted         <= rz_ctl.ok;
        o_packet_word      <= (rz_ctl.ok && rz_ctl.with_packet)
                              ? ({WRITE_CMD, 16'h0000} | 24'(w_code)) : 24'd0;
        o_dac_code         <= rz_ctl.ok ? w_code : '0;
        o_reported_voltage <= rz_ctl.ok ? $signed(w_rv) : 32'sd0;
    end

endmodule

/* rtl/calibrated_dac_code_converter_top.sv */
// A request passes from start through the encode and report pipelines to o_done.
// Throughput: one request per clock; busy stays low.
// The divide by full scale is a restoring divider, one quotient bit per stage.
// Synchronous active-low reset clears the pipeline valids and loads register defaults.
// Results appear on o_done for one cycle and cannot be stalled.
module calibrated_dac_code_converter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic signed [31:0]          i_voltage,
    input  logic [19:0]                 i_raw_code,
    input  logic [23:0]                 i_readback_word,
    output logic                        o_done,
    output logic                        o_accepted,
    output logic [23:0]                 o_packet_word,
    output logic [19:0]                 o_dac_code,
    output logic signed [31:0]          o_reported_voltage,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import dcc_pkg::*;

    t_cfg                 w_cfg;
    t_ctl                 w_ctl;
    logic [CODE_BITS-1:0] w_enc_code, w_in_code;

    assign busy      = 1'b0;
    assign w_in_code = (i_action == ACT_RAW) ? i_raw_code[CODE_BITS-1:0]
                                             : i_readback_word[CODE_BITS-1:0];

    dcc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dcc_encode u_enc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_action  (i_action),
        .i_voltage (i_voltage),
        .i_code    (w_in_code),
        .i_cfg     (w_cfg),
        .o_ctl     (w_ctl),
        .o_code    (w_enc_code)
    );

    dcc_report u_rep (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .i_code             (w_enc_code),
        .i_cfg              (w_cfg),
        .o_done             (o_done),
        .o_accepted         (o_accepted),
        .o_packet_word      (o_packet_word),
        .o_dac_code         (o_dac_code),
        .o_reported_voltage (o_reported_voltage)
    );

    // every request comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("request result missing");

    // rejected or undefined requests carry all-zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_accepted) |->
        (o_packet_word == 24'd0 && o_dac_code == 20'd0 && o_reported_voltage == 32'sd0))
        else $error("rejected result not cleared");

    // a non-zero packet always holds the write command and the reported code
    a_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_packet_word != 24'd0) |->
        (o_packet_word[23:20] == WRITE_CMD[7:4] && o_packet_word[19:0] == o_dac_code))
        else $error("packet and code disagree");

endmodule

/* tb/dac_code_checker.sv */
module dac_code_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_voltage,
    input  logic [19:0]        i_raw_code,
    input  logic [23:0]        i_readback_word,
    input  logic               i_done,
    input  logic               i_accepted,
    input  logic [23:0]        i_packet_word,
    input  logic [19:0]        i_dac_code,
    input  logic signed [31:0] i_reported_voltage,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    import dcc_pkg::*;

    typedef struct {
        logic        accepted;
        logic [23:0] packet_word;
        logic [19:0] dac_code;
        logic [31:0] reported_voltage;
    } t_conversion;

    t_conversion conversion_q[$];

    // shadow copy of the calibration registers
    longint upper_q, lower_q, gain_q, ginv_q, offs_q, fs_q;

    function automatic longint div_trunc(longint num, longint den);
        longint m;
        m = (num < 0 ? -num : num) / den;
        return num < 0 ? -m : m;
    endfunction

    function automatic longint mul_shift29(longint a, longint b);
        longint m;
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> 29;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic logic [31:0] reported_for(logic [19:0] code);
        longint fs, v, r;
        fs = (fs_q == 0) ? 1 : fs_q;
        if (code <= 20'd524287) v = longint'(code) * fs / 524287;
        else v = -((1048576 - longint'(code)) * fs / 524288);
        r = mul_shift29(gain_q, v + offs_q);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_conversion convert(logic [1:0] act, logic signed [31:0] volts,
                                            logic [19:0] raw, logic [23:0] rb);
        t_conversion res;
        longint c, s, fs, vv;
        res = '{1'b0, 24'd0, 20'd0, 32'd0};
        fs = (fs_q == 0) ? 1 : fs_q;
        case (act)
            ACT_SET: begin
                vv = longint'(volts);
                if (vv <= upper_q && vv >= lower_q) begin
                    c = mul_shift29(vv, ginv_q) - offs_q;
                    s = div_trunc(c * (c >= 0 ? 524287 : 524288), fs);
                    if (s > 524287) s = 524287;
                    if (s < -524288) s = -524288;
                    res.accepted = 1'b1;
                    res.dac_code = s[19:0];
                    res.packet_word = (24'(WRITE_CMD) << 16) | {4'h0, s[19:0]};
                    res.reported_voltage = reported_for(s[19:0]);
                end
            end
            ACT_RAW: begin
                res.accepted = 1'b1;
                res.dac_code = raw;
                res.packet_word = (24'(WRITE_CMD) << 16) | {4'h0, raw};
                res.reported_voltage = reported_for(raw);
            end
            ACT_DEC: begin
                res.accepted = 1'b1;
                res.dac_code = rb[19:0];
                res.reported_voltage = reported_for(rb[19:0]);
            end
            default: ;
        endcase
        return res;
    endfunction

    assign o_pending = conversion_q.size();

    // track register writes, predict on requests, compare on results
    always @(posedge i_clk) begin
        t_conversion exp_r;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            upper_q <= 655360;
            lower_q <= -655360;
            gain_q  <= 536870912;
            ginv_q  <= 536870912;
            offs_q  <= 0;
            fs_q    <= 655360;
            o_fail_count <= 0;
            conversion_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_UPPER: upper_q <= longint'($signed(i_pwdata));
                    REG_LOWER: lower_q <= longint'($signed(i_pwdata));
                    REG_GAIN:  gain_q  <= longint'($signed(i_pwdata));
                    REG_GINV:  ginv_q  <= longint'($signed(i_pwdata));
                    REG_OFFS:  offs_q  <= longint'($signed(i_pwdata));
                    REG_FS:    fs_q    <= longint'(i_pwdata[30:0]);
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                conversion_q.push_back(convert(i_action, i_voltage, i_raw_code,
                                               i_readback_word));
            if (i_done) begin
                if (conversion_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errs++;
                end else begin
                    exp_r = conversion_q.pop_front();
                    if (i_accepted !== exp_r.accepted) begin
                        $error("accepted exp %0h got %0h", exp_r.accepted, i_accepted);
                        errs++;
                    end
                    if (i_packet_word !== exp_r.packet_word) begin
                        $error("packet_word exp %0h got %0h", exp_r.packet_word,
                               i_packet_word);
                        errs++;
                    end
                    if (i_dac_code !== exp_r.dac_code) begin
                        $error("dac_code exp %0h got %0h", exp_r.dac_code, i_dac_code);
                        errs++;
                    end
                    if (i_reported_voltage !== exp_r.reported_voltage) begin
                        $error("reported_voltage exp %0h got %0h",
                               exp_r.reported_voltage, i_reported_voltage);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

/* tb/tb_calibrated_dac_code_converter_top.sv */
module tb_calibrated_dac_code_converter_top;
    import dcc_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_action = ACT_SET;
    logic signed [31:0] i_voltage = '0;
    logic [19:0]        i_raw_code = '0;
    logic [23:0]        i_readback_word = '0;
    logic               o_done, o_accepted;
    logic [23:0]        o_packet_word;
    logic [19:0]        o_dac_code;
    logic signed [31:0] o_reported_voltage;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0, prdata;
    logic               pready;
    int                 fail_count, pending;
    int                 burst_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    calibrated_dac_code_converter_top i_dut (.*);

    dac_code_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_action(i_action), .i_voltage(i_voltage), .i_raw_code(i_raw_code),
        .i_readback_word(i_readback_word), .i_done(o_done), .i_accepted(o_accepted),
        .i_packet_word(o_packet_word), .i_dac_code(o_dac_code),
        .i_reported_voltage(o_reported_voltage), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // setup, access, then idle
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'({idx, 2'b00}); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_calibration(logic [31:0] up, logic [31:0] lo, logic [31:0] g,
                                     logic [31:0] gi, logic [31:0] off, logic [31:0] fs);
        reg_write(REG_UPPER, up);
        reg_write(REG_LOWER, lo);
        reg_write(REG_GAIN, g);
        reg_write(REG_GINV, gi);
        reg_write(REG_OFFS, off);
        reg_write(REG_FS, fs);
    endtask

    // present one request, with bursty gaps ahead of it
    task automatic send_request(logic [1:0] act, logic [31:0] v, logic [19:0] raw,
                                logic [23:0] rb);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1; i_action <= act; i_voltage <= v;
        i_raw_code <= raw; i_readback_word <= rb;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // voltages: mostly inside typical limits, some anywhere
    function automatic logic [31:0] pick_voltage();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 1_400_000)) - 700_000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'(int'($urandom_range(0, 1_310_720)) - 655_360);
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [1:0] act;
        repeat (count) begin
            act = ($urandom_range(0, 19) == 0) ? ACT_UNDEF : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 1)) act = ACT_SET;
            send_request(act, pick_voltage(), 20'($urandom()), 24'($urandom()));
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at reset calibration
        send_request(ACT_SET, 32'sd655360, '0, '0);
        send_request(ACT_SET, -32'sd655360, '0, '0);
        send_request(ACT_SET, 32'sd655361, '0, '0);
        send_request(ACT_SET, -32'sd655361, '0, '0);
        send_request(ACT_SET, 32'sd0, '0, '0);
        send_request(ACT_SET, -32'sd1, '0, '0);
        send_request(ACT_SET, 32'h7FFF_FFFF, '0, '0);
        send_request(ACT_SET, 32'h8000_0000, '0, '0);
        send_request(ACT_RAW, '0, 20'h00000, '0);
        send_request(ACT_RAW, '0, 20'h7FFFF, '0);
        send_request(ACT_RAW, '0, 20'h80000, '0);
        send_request(ACT_RAW, '0, 20'hFFFFF, '0);
        send_request(ACT_DEC, '0, '0, 24'hFFFFFF);
        send_request(ACT_DEC, '0, '0, 24'hF80000);
        send_request(ACT_DEC, '0, '0, 24'h07FFFF);
        send_request(ACT_UNDEF, 32'sd100, 20'h12345, 24'h123456);
        drain();

        // extremes: open limits, saturating gains and offset, tiny full scale
        write_calibration(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'd1);
        send_request(ACT_SET, 32'h7FFF_FFFF, '0, '0);
        send_request(ACT_SET, 32'h8000_0000, '0, '0);
        send_request(ACT_RAW, '0, 20'h7FFFF, '0);
        send_request(ACT_DEC, '0, '0, 24'h080000);
        random_phase(300);

        // crossed limits, negative gain, full scale at maximum
        write_calibration(32'hFFF6_0000, 32'h000A_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF);
        random_phase(200);

        // full scale zero treated as one
        write_calibration(32'h000A_0000, 32'hFFF6_0000, 32'h2000_0000, 32'h2000_0000,
                          32'd0, 32'd0);
        random_phase(150);

        // random calibrations near nominal, a few fully random
        repeat (6) begin
            write_calibration(32'(int'($urandom_range(0, 1_000_000))),
                              32'(-int'($urandom_range(0, 1_000_000))),
                              32'(int'($urandom_range(0, 300_000_000)) + 400_000_000),
                              32'(int'($urandom_range(0, 300_000_000)) + 400_000_000),
                              32'(int'($urandom_range(0, 20_000)) - 10_000),
                              32'($urandom_range(1, 1_000_000)));
            random_phase(175);
        end
        repeat (2) begin
            write_calibration($urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom());
            random_phase(60);
        end

        if (fail_count == 0)
            $display("calibrated_dac_code_converter_top regression: pass");
        else
            $display("calibrated_dac_code_converter_top regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("calibrated_dac_code_converter_top regression: fail");
        $finish;
    end
endmodule
